FILE: rtl/core/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Servo frame deframer package
// Shared constants, phase encoding and result record for the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  localparam logic [7:0] HEADER_BYTE  = 8'h55;
  localparam logic [7:0] FIXED_LEN    = 8'd3;
  localparam int         PARAM_LANES  = 8;
  localparam int         LANE_IDX_W   = 3;
  localparam int         PARAM_WORD_W = 8 * PARAM_LANES;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_CMD   = 3'd4,
    PH_PARAM = 3'd5,
    PH_SUM   = 3'd6
  } phase_t;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_CSUM    = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;

  typedef struct packed {
    logic [1:0]              status;
    logic [7:0]              servo_id;
    logic [7:0]              command;
    logic [3:0]              param_count;
    logic [PARAM_WORD_W-1:0] param_word;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/sfd_in_reg.sv
// ----------------------------------------------------------------------------
// Deframer input register
// Holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       advance,
  output logic            in_stall,
  output logic            hold_valid,
  output logic [7:0]      hold_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  // The held byte stays while the parser cannot take it.
  assign in_stall  = valid_r && !advance;
  assign valid_nxt = in_stall ? 1'b1 : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

`default_nettype wire

FILE: rtl/core/sfd_parser.sv
// ----------------------------------------------------------------------------
// Deframer frame parser
// Phase machine, running checksum and parameter packing, one byte a pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_parser import sfd_pkg::*; #(
  parameter int MAX_PARAMS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       advance,
  input  wire logic [7:0] rx_byte,
  output logic            res_valid,
  output result_t         res
);

  localparam logic [7:0] MAX_LEN = 8'(int'(FIXED_LEN) + MAX_PARAMS);

  phase_t                  phase_r, phase_nxt;
  logic [7:0]              id_r, id_nxt;
  logic [7:0]              len_r, len_nxt;
  logic [7:0]              cmd_r, cmd_nxt;
  logic [PARAM_WORD_W-1:0] buf_r, buf_nxt;
  logic [3:0]              idx_r, idx_nxt;
  logic [7:0]              sum_r, sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      id_r    <= '0;
      len_r   <= '0;
      cmd_r   <= '0;
      buf_r   <= '0;
      idx_r   <= '0;
      sum_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      buf_r   <= buf_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    buf_nxt   = buf_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    res_valid = 1'b0;
    res       = '0;
    case (phase_r)
      PH_HUNT2: begin
        phase_nxt = (rx_byte == HEADER_BYTE) ? PH_ID : PH_HUNT1;
      end
      PH_ID: begin
        id_nxt    = rx_byte;
        sum_nxt   = rx_byte;
        buf_nxt   = '0;
        idx_nxt   = '0;
        cmd_nxt   = '0;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt = rx_byte;
        if (rx_byte < FIXED_LEN || rx_byte > MAX_LEN) begin
          phase_nxt    = PH_HUNT1;
          res_valid    = 1'b1;
          res.status   = ST_BAD_LEN;
          res.servo_id = id_r;
        end else begin
          sum_nxt   = sum_r + rx_byte;
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        sum_nxt   = sum_r + rx_byte;
        phase_nxt = (len_r == FIXED_LEN) ? PH_SUM : PH_PARAM;
      end
      PH_PARAM: begin
        for (int k = 0; k < PARAM_LANES; k++) begin
          if (idx_r[LANE_IDX_W-1:0] == LANE_IDX_W'(k)) begin
            buf_nxt[k*8 +: 8] = buf_r[k*8 +: 8] | rx_byte;
          end
        end
        sum_nxt = sum_r + rx_byte;
        idx_nxt = idx_r + 4'd1;
        // The count including this byte decides whether the checksum is next.
        if (({4'b0, idx_nxt} + FIXED_LEN) >= len_r) begin
          phase_nxt = PH_SUM;
        end
      end
      PH_SUM: begin
        phase_nxt       = PH_HUNT1;
        res_valid       = 1'b1;
        res.status      = (~sum_r == rx_byte) ? ST_GOOD : ST_CSUM;
        res.servo_id    = id_r;
        res.command     = cmd_r;
        res.param_count = 4'(len_r - FIXED_LEN);
        res.param_word  = buf_r;
      end
      default: begin
        phase_nxt = (rx_byte == HEADER_BYTE) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/sfd_out_reg.sv
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_out_reg import sfd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  result_t   res,
  input  wire logic out_stall,
  output logic      out_valid,
  output logic      free,
  output result_t   out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

FILE: rtl/core/servo_frame_deframer.sv
// ----------------------------------------------------------------------------
// Servo frame deframer
// Recognises 0x55 0x55 id length command params checksum frames, byte-serial.
// ----------------------------------------------------------------------------
// A completing byte passes the input register, then the parser pass into the
// result register. Throughput: one byte per cycle, set by the single parser
// pass per byte, unless a finished result waits on a stalled output.
// Reset: synchronous, active low; clears both valid flags and the parser,
// which then hunts for the first header byte.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_frame_deframer import sfd_pkg::*; #(
  parameter int MAX_PARAMS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [7:0]       out_servo_id,
  output logic [7:0]       out_command,
  output logic [3:0]       out_param_count,
  output logic [63:0]      out_param_word
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       advance;
  logic       res_valid;
  logic       out_free;
  result_t    res;
  result_t    out_res;

  // The input register parts the upstream side from the parser, so a byte
  // is taken every cycle unless the held byte gives a result while the
  // result register is still occupied and stalled.
  sfd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_byte    (in_rx_byte),
    .advance    (advance),
    .in_stall   (in_stall),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  // The parser only moves on when the held byte can be fully dealt with:
  // bytes that give no result always pass, those that do need a free slot.
  assign advance = hold_valid && (!res_valid || out_free);

  sfd_parser #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .rx_byte   (hold_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // The result register keeps a finished frame until its transfer, while
  // further bytes continue to flow into the parser.
  sfd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (out_free),
    .out_res   (out_res)
  );

  assign out_status      = out_res.status;
  assign out_servo_id    = out_res.servo_id;
  assign out_command     = out_res.command;
  assign out_param_count = out_res.param_count;
  assign out_param_word  = out_res.param_word;

endmodule

`default_nettype wire

FILE: rtl/core/sfd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Watches the top-level ports for result consistency and handshake holding.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_checker import sfd_pkg::*; #(
  parameter int MAX_PARAMS = 8
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic [7:0]  out_command,
  input wire logic [3:0]  out_param_count,
  input wire logic [63:0] out_param_word
);

  // A stalled result must still be offered in the next cycle.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_GOOD || out_status == ST_CSUM ||
                   out_status == ST_BAD_LEN))
    else $error("unknown status code");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_param_count) <= MAX_PARAMS))
    else $error("parameter count beyond the maximum");

  a_bad_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BAD_LEN |->
      out_command == 8'd0 && out_param_count == 4'd0 && out_param_word == 64'd0)
    else $error("bad length result carries frame contents");

endmodule

bind servo_frame_deframer sfd_checker #(
  .MAX_PARAMS (MAX_PARAMS)
) u_sfd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_command     (out_command),
  .out_param_count (out_param_count),
  .out_param_word  (out_param_word)
);

`default_nettype wire
